### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers for the thermostat core; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MFHT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mfht check failed");
`define MFHT_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) \
        else $error("mfht sequence check failed");
`else
`define MFHT_ASSERT(lbl, clk, rst_n, prop)
`define MFHT_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

### rtl/core/mfht_pkg.sv
// ----------------------------------------------------------------------------
// mfht_pkg
// Shared widths, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mfht_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int FULL_SCALE  = (1 << SAMPLE_BITS) - 1;
    localparam int SPAN_NUM    = 353;
    localparam int SPAN_W      = 9;

    localparam int TEMP_W  = 9;
    localparam int TGT_W   = 13;
    localparam int HYS_W   = 10;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 2;

    // median * SPAN_NUM
    localparam int PROD_W = SAMPLE_BITS + SPAN_W;
    // 16 * median * SPAN_NUM
    localparam int LHS_W  = PROD_W + 4;
    // (target +/- band) scaled by FULL_SCALE
    localparam int BASE_W = TGT_W + 1;
    localparam int THR_W  = BASE_W + SAMPLE_BITS;

    localparam logic [TGT_W-1:0] TGT_RST = TGT_W'(480);
    localparam logic [HYS_W-1:0] HYS_RST = HYS_W'(32);

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HYST   = CFG_IDX_W'(1);

    typedef logic [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        logic load;       // new sample accepted: write ring, load sorter
        logic sort_step;  // one compare-swap pass
        logic sort_odd;   // pass works on odd pairs
        logic prod;       // scale median, form threshold
        logic decide;     // mode update and result load
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_busy;   // result register full and stalled
        logic warming;    // still in warm-up
    } t_ctrl_status;

endpackage

### rtl/core/mfht_ctrl.sv
// ----------------------------------------------------------------------------
// mfht_ctrl
// Sequencer: accept, WINDOW sort passes, scale, decide.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mfht_ctrl #(
    parameter int WINDOW = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  mfht_pkg::t_ctrl_status i_status,
    output mfht_pkg::t_ctrl_cmd   o_cmd
);

    localparam int PASS_W = $clog2(WINDOW);
    localparam logic [PASS_W-1:0] LAST_PASS = PASS_W'(WINDOW - 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SORT   = 2'd1;
    localparam logic [1:0] S_PROD   = 2'd2;
    localparam logic [1:0] S_DECIDE = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [PASS_W-1:0] r_pass,  n_pass;

    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_pass     = '0;
                    n_state    = S_SORT;
                end
            end
            S_SORT: begin
                o_cmd.sort_step = 1'b1;
                o_cmd.sort_odd  = r_pass[0];
                if (r_pass == LAST_PASS) begin
                    n_state = S_PROD;
                end else begin
                    n_pass = r_pass + 1'b1;
                end
            end
            S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = S_DECIDE;
            end
            S_DECIDE: begin
                // hold until the result register can take the new item
                if (!i_status.out_busy) begin
                    o_cmd.decide = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= '0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

    `MFHT_ASSERT(a_pass_range, i_clk, i_rst_n, r_pass <= LAST_PASS)
    `MFHT_ASSERT_NEXT(a_sort_done, i_clk, i_rst_n,
        (r_state == S_SORT && r_pass == LAST_PASS), (r_state == S_PROD))
    `MFHT_ASSERT_NEXT(a_decide_hold, i_clk, i_rst_n,
        (r_state == S_DECIDE && i_status.out_busy), (r_state == S_DECIDE))
    `MFHT_ASSERT_NEXT(a_load_sorts, i_clk, i_rst_n,
        o_cmd.load, (r_state == S_SORT && r_pass == '0))

endmodule

### rtl/core/mfht_dp.sv
// ----------------------------------------------------------------------------
// mfht_dp
// Sample ring, odd-even transposition sorter, scaling and hysteresis logic.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mfht_dp #(
    parameter int WINDOW = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mfht_pkg::t_ctrl_cmd                 i_cmd,
    output mfht_pkg::t_ctrl_status              o_status,
    input  logic                                i_cfg_we,
    input  logic [mfht_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mfht_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic [mfht_pkg::SAMPLE_BITS-1:0]    i_adc_sample,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [mfht_pkg::TEMP_W-1:0]         o_temperature_deg,
    output logic                                o_heater_on,
    output logic                                o_fan_on,
    output logic                                o_control_active
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 2);
    localparam int MED    = WINDOW / 2;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0]  WARM_END  = CNT_W'(WINDOW);
    localparam logic [CNT_W-1:0]  WARM_DONE = CNT_W'(WINDOW + 1);
    localparam int QW = mfht_pkg::PROD_W - mfht_pkg::SAMPLE_BITS;

    mfht_pkg::t_sample r_ring [WINDOW];
    mfht_pkg::t_sample r_sort [WINDOW];
    mfht_pkg::t_sample n_sort [WINDOW];
    logic [SLOT_W-1:0] r_slot;
    logic [CNT_W-1:0]  r_warm, n_warm;
    logic              r_cool, n_cool;
    logic              n_active;

    logic [mfht_pkg::TGT_W-1:0] r_tgt;
    logic [mfht_pkg::HYS_W-1:0] r_hys;

    logic [mfht_pkg::PROD_W-1:0] r_prod;
    logic [mfht_pkg::THR_W-1:0]  r_thr;
    logic                        r_thr_neg;
    logic [mfht_pkg::BASE_W-1:0] base;
    logic                        base_neg;
    logic [mfht_pkg::BASE_W-1:0] tgt_ext, hys_ext;

    logic [mfht_pkg::THR_W-1:0]        lhs;
    logic [QW-1:0]                     q0;
    logic [mfht_pkg::SAMPLE_BITS:0]    rem;
    logic [mfht_pkg::TEMP_W-1:0]       temp;

    logic                         r_out_valid;
    logic [mfht_pkg::TEMP_W-1:0]  r_temp;
    logic                         r_heater, r_fan, r_active;

    // one transposition pass; pairs of one parity never overlap
    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            n_sort[i] = r_sort[i];
        end
        for (int i = 0; i < WINDOW - 1; i++) begin
            if ((i[0] == i_cmd.sort_odd) && (r_sort[i] > r_sort[i+1])) begin
                n_sort[i]   = r_sort[i+1];
                n_sort[i+1] = r_sort[i];
            end
        end
    end

    // threshold for whichever compare the decide cycle will make
    always_comb begin
        tgt_ext  = mfht_pkg::BASE_W'(r_tgt);
        hys_ext  = mfht_pkg::BASE_W'(r_hys);
        base     = tgt_ext;
        base_neg = 1'b0;
        priority if (r_warm == WARM_END) begin
            base = tgt_ext;
        end else if (!r_cool) begin
            base = tgt_ext + hys_ext;
        end else begin
            base     = tgt_ext - hys_ext;
            base_neg = (tgt_ext < hys_ext);
        end
    end

    // divide by 2^N-1: quotient estimate plus one correction step
    always_comb begin
        lhs  = mfht_pkg::THR_W'({r_prod, 4'b0000});
        q0   = r_prod[mfht_pkg::PROD_W-1:mfht_pkg::SAMPLE_BITS];
        rem  = (mfht_pkg::SAMPLE_BITS+1)'(r_prod[mfht_pkg::SAMPLE_BITS-1:0])
             + (mfht_pkg::SAMPLE_BITS+1)'(q0);
        temp = mfht_pkg::TEMP_W'(q0)
             + mfht_pkg::TEMP_W'(rem >= (mfht_pkg::SAMPLE_BITS+1)'(mfht_pkg::FULL_SCALE));
    end

    always_comb begin
        n_warm   = r_warm;
        n_cool   = r_cool;
        n_active = 1'b1;
        priority if (r_warm < WARM_END) begin
            n_warm   = r_warm + 1'b1;
            n_active = 1'b0;
        end else if (r_warm == WARM_END) begin
            n_cool = (lhs >= r_thr);
            n_warm = WARM_DONE;
        end else if (!r_cool) begin
            if (lhs >= r_thr) begin
                n_cool = 1'b1;
            end
        end else begin
            if (!r_thr_neg && (lhs <= r_thr)) begin
                n_cool = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_ring[i] <= '0;
            end
            r_slot      <= '0;
            r_warm      <= '0;
            r_cool      <= 1'b0;
            r_tgt       <= mfht_pkg::TGT_RST;
            r_hys       <= mfht_pkg::HYS_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == mfht_pkg::CFG_TARGET) begin
                    r_tgt <= i_cfg_data[mfht_pkg::TGT_W-1:0];
                end else if (i_cfg_index == mfht_pkg::CFG_HYST) begin
                    r_hys <= i_cfg_data[mfht_pkg::HYS_W-1:0];
                end
            end
            if (i_cmd.load) begin
                r_ring[r_slot] <= i_adc_sample;
                r_slot <= (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
            end
            if (i_cmd.decide) begin
                r_warm      <= n_warm;
                r_cool      <= n_cool;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_sort[i] <= (r_slot == SLOT_W'(i)) ? i_adc_sample : r_ring[i];
            end
        end else if (i_cmd.sort_step) begin
            r_sort <= n_sort;
        end
        if (i_cmd.prod) begin
            r_prod <= mfht_pkg::PROD_W'(r_sort[MED])
                    * mfht_pkg::PROD_W'(mfht_pkg::SPAN_NUM);
            r_thr  <= mfht_pkg::THR_W'(base) * mfht_pkg::THR_W'(mfht_pkg::FULL_SCALE);
            r_thr_neg <= base_neg;
        end
        if (i_cmd.decide) begin
            r_temp   <= temp;
            r_active <= n_active;
            r_heater <= n_active & ~n_cool;
            r_fan    <= n_active & n_cool;
        end
    end

    assign o_status.out_busy = r_out_valid & i_out_stall;
    assign o_status.warming  = (r_warm < WARM_END);

    assign o_out_valid       = r_out_valid;
    assign o_temperature_deg = r_temp;
    assign o_heater_on       = r_heater;
    assign o_fan_on          = r_fan;
    assign o_control_active  = r_active;

    `MFHT_ASSERT(a_warm_range, i_clk, i_rst_n, r_warm <= WARM_DONE)
    `MFHT_ASSERT(a_slot_range, i_clk, i_rst_n, r_slot <= LAST_SLOT)
    `MFHT_ASSERT(a_drive_excl, i_clk, i_rst_n,
        r_out_valid |-> (r_active == (r_heater ^ r_fan)))
    `MFHT_ASSERT_NEXT(a_active_sticky, i_clk, i_rst_n,
        (i_cmd.decide && !o_status.warming), (r_active && r_warm == WARM_DONE))

endmodule

### rtl/core/median_filtered_hysteresis_thermostat.sv
// ----------------------------------------------------------------------------
// median_filtered_hysteresis_thermostat
// Median-of-WINDOW filter on converter samples, scaling to whole degrees,
// and a hysteresis heat/cool controller after a warm-up of WINDOW samples.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  sample    in         i_in_valid / o_in_stall   i_adc_sample
//  result    out        o_out_valid / i_out_stall temperature, heater, fan, active
//  config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// Each item goes through accept, WINDOW odd-even transposition passes
// through one compare-swap row, scale and decide, in that order.
// One result is produced per item and held in an output register; the
// decide step waits while that register is full and stalled.
// Reset is synchronous: ring cleared, warm-up restarted, config registers at defaults.
// ----------------------------------------------------------------------------
module median_filtered_hysteresis_thermostat #(
    parameter int WINDOW = 5
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mfht_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mfht_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [mfht_pkg::SAMPLE_BITS-1:0]   i_adc_sample,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [mfht_pkg::TEMP_W-1:0]        o_temperature_deg,
    output logic                               o_heater_on,
    output logic                               o_fan_on,
    output logic                               o_control_active
);

    mfht_pkg::t_ctrl_cmd    cmd;
    mfht_pkg::t_ctrl_status status;

    mfht_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mfht_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_adc_sample      (i_adc_sample),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_temperature_deg (o_temperature_deg),
        .o_heater_on       (o_heater_on),
        .o_fan_on          (o_fan_on),
        .o_control_active  (o_control_active)
    );

endmodule
